// ----- src/key_binding_table_macros.svh -----
// Assertion macros used by the key binding table checker.
`ifndef KEY_BINDING_TABLE_MACROS_SVH
`define KEY_BINDING_TABLE_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define KBT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block's own clock and reset.
`define KBT_ASSERT(label, prop, msg) `KBT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- src/kbt_pkg.sv -----
// Types shared by the key binding table modules.
package kbt_pkg;

  typedef enum logic {
    FUNC_DEFINE = 1'b0,
    FUNC_LOOKUP = 1'b1
  } kbt_func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } kbt_status_e;

  typedef struct packed {
    kbt_func_e   func;
    logic [7:0]  mod_mask;
    logic [7:0]  key_code;
    logic [15:0] name_handle;
  } kbt_req_t;

  typedef struct packed {
    kbt_status_e status;
    logic        hit;
    logic [15:0] bound_handle;
  } kbt_res_t;

  // One stored binding.
  typedef struct packed {
    logic [7:0]  mods;
    logic [7:0]  key;
    logic [15:0] handle;
  } kbt_entry_t;

  // Port controls from the sequencer to the binding memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } kbt_mem_ctl_t;

endpackage

// ----- src/kbt_mem.sv -----
// Single-port binding memory with a registered read.
module kbt_mem
  import kbt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IDX_W   = 4
) (
  input  logic               clk_i,
  input  kbt_mem_ctl_t       ctl_i,
  input  logic [IDX_W-1:0]   addr_i,
  input  kbt_entry_t         wdata_i,
  output kbt_entry_t         rdata_o
);

  kbt_entry_t mem [ENTRIES];
  kbt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/kbt_ctrl.sv -----
// Scan sequencer, valid bits and result register of the key binding table.
module kbt_ctrl
  import kbt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IDX_W   = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kbt_req_t         in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output kbt_res_t         out_res_o,
  output kbt_mem_ctl_t     mem_ctl_o,
  output logic [IDX_W-1:0] mem_addr_o,
  output kbt_entry_t       mem_wdata_o,
  input  kbt_entry_t       mem_rdata_i
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  kbt_req_t         req_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             found_q, found_d;
  logic [IDX_W-1:0] found_idx_q;
  logic [15:0]      found_handle_q;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q;
  logic [ENTRIES-1:0] valid_q;
  logic             out_valid_q;
  kbt_res_t         out_res_q, res_d;

  logic             accept;
  logic             cmp_match, cmp_free;
  logic             load;
  logic             do_write;
  logic [IDX_W-1:0] wr_idx;

  assign accept = in_valid_i && in_ready_o;

  // The read issued last cycle is compared against the held chord.
  assign cmp_match = cmp_vld_q && valid_q[cmp_idx_q] &&
                     (mem_rdata_i.mods == req_q.mod_mask) &&
                     (mem_rdata_i.key == req_q.key_code);
  assign cmp_free  = cmp_vld_q && !valid_q[cmp_idx_q];

  assign load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    res_d        = '{status: ST_OK, hit: 1'b0, bound_handle: 16'd0};
    do_write     = 1'b0;
    wr_idx       = found_q ? found_idx_q : free_idx_q;
    if (req_q.func == FUNC_LOOKUP) begin
      res_d.hit          = found_q;
      res_d.bound_handle = found_q ? found_handle_q : 16'd0;
    end else if (req_q.name_handle == 16'd0) begin
      res_d.status = ST_INVALID;
    end else if (found_q || free_q) begin
      do_write = 1'b1;
    end else begin
      res_d.status = ST_FULL;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmp_vld_d = 1'b0;
    found_d   = found_q || cmp_match;
    free_d    = free_q || cmp_free;
    mem_ctl_o = '{rd_en: 1'b0, wr_en: 1'b0};
    mem_addr_o = idx_q;
    unique case (state_q)
      S_IDLE: begin
        found_d = 1'b0;
        free_d  = 1'b0;
        idx_d   = '0;
        if (accept) begin
          // An empty handle on define needs no scan.
          if (in_req_i.func == FUNC_DEFINE && in_req_i.name_handle == 16'd0) begin
            state_d = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_ctl_o.rd_en = 1'b1;
        cmp_vld_d       = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = S_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_LAST: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        mem_addr_o = wr_idx;
        if (load) begin
          mem_ctl_o.wr_en = do_write;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mem_wdata_o = '{mods: req_q.mod_mask, key: req_q.key_code,
                         handle: req_q.name_handle};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      free_q    <= free_d;
      if (load) begin
        out_valid_q <= 1'b1;
        if (do_write) begin
          valid_q[wr_idx] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    cmp_idx_q <= idx_q;
    if (cmp_match && !found_q) begin
      found_idx_q    <= cmp_idx_q;
      found_handle_q <= mem_rdata_i.handle;
    end
    if (cmp_free && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    if (load) begin
      out_res_q <= res_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ----- src/key_binding_table.sv -----
// Key binding table: define and look up chord-to-handle bindings.
// Each request carries a chord (modifier mask and key code) and either defines a binding
// or looks one up. The bindings sit in a single-port memory with a registered read; a
// lookup or a define with a nonzero handle scans every entry, one read per cycle, and a
// define with an empty handle skips the scan. A define with a nonzero handle then writes
// the matching entry, or else the lowest free one, in its final cycle. The valid bits
// are flip-flops cleared by reset, so the table is empty and usable right after reset.
// A finished result waits in an output register; the next request is taken while it is
// still pending.
module key_binding_table
  import kbt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  kbt_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output kbt_res_t out_res_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  kbt_mem_ctl_t    mem_ctl;
  logic [IdxW-1:0] mem_addr;
  kbt_entry_t      mem_wdata;
  kbt_entry_t      mem_rdata;

  kbt_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IdxW)
  ) u_kbt_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  kbt_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IdxW)
  ) u_kbt_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- src/kbt_checker.sv -----
// Port-level assertions for the key binding table and their bind.
`include "key_binding_table_macros.svh"

module kbt_checker
  import kbt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input kbt_req_t in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input kbt_res_t out_res_o
);

  // A stalled result must hold.
  `KBT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o), "result changed while stalled")

  // One request at a time: the block is busy right after taking one.
  `KBT_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "request taken while busy")

  `KBT_ASSERT(a_hit_ok, out_valid_o && out_res_o.hit |-> out_res_o.status == ST_OK, "hit with error status")

  `KBT_ASSERT(a_miss_zero, out_valid_o && !out_res_o.hit |-> out_res_o.bound_handle == 16'd0, "handle without hit")

endmodule

bind key_binding_table kbt_checker u_kbt_checker (.*);
